// ===== sv/zsn_pkg.sv =====
// Shared constants, codes and types of the feature z-score normalizer.
package zsn_pkg;

	// Field widths of one input word and one result word
	localparam int ACT_W   = 2;
	localparam int VAL_W   = 32;
	localparam int ROW_W   = 10;
	localparam int FEAT_W  = 4;
	localparam int STD_W   = 31;

	// Configuration register widths and reset values
	localparam int NF_W       = 5;
	localparam int NR_W       = 11;
	localparam int NF_RESET   = 16;
	localparam int NR_RESET   = 1024;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	// Defaults of the top-level size parameters
	localparam int MAX_ROWS_DEF     = 1024;
	localparam int MAX_FEATURES_DEF = 16;

	// Serial arithmetic unit widths
	localparam int DVD_W  = 64;
	localparam int DVS_W  = 32;
	localparam int SQ_W   = 64;
	localparam int ROOT_W = 32;
	localparam int MUL_W  = 32;

	// 1.0 in Q15.16
	localparam logic [STD_W-1:0] ONE_Q16 = 31'd65536;
	localparam logic [STD_W-1:0] STD_MAX = 31'h7FFF_FFFF;

	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [VAL_W-1:0]  sample_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [FEAT_W-1:0] feat_t;
	typedef logic [STD_W-1:0]  std_t;

	// Action codes
	localparam action_t ACT_LOAD   = 2'd0;
	localparam action_t ACT_FINISH = 2'd1;
	localparam action_t ACT_READ   = 2'd2;

	// Register indexes (word address bit 2)
	localparam logic REG_NUM_FEATURES = 1'b0;
	localparam logic REG_NUM_ROWS     = 1'b1;

endpackage

// ===== sv/zsn_in_if.sv =====
// Input channel of the normalizer: action word with sample and coordinates.
interface zsn_in_if;
	logic            valid;
	logic            ready;
	zsn_pkg::action_t action;
	zsn_pkg::sample_t value;
	zsn_pkg::row_t    row;
	zsn_pkg::feat_t   feature;

	modport source(output valid, action, value, row, feature, input ready);
	modport sink(input valid, action, value, row, feature, output ready);
endinterface

// ===== sv/zsn_out_if.sv =====
// Result channel of the normalizer: statistics or normalized element.
interface zsn_out_if;
	logic             valid;
	logic             ready;
	zsn_pkg::feat_t   feature_index;
	zsn_pkg::sample_t mean;
	zsn_pkg::std_t    std_dev;
	zsn_pkg::sample_t normalized;
	logic             status;
	logic             last;

	modport source(output valid, feature_index, mean, std_dev, normalized, status, last,
		input ready);
	modport sink(input valid, feature_index, mean, std_dev, normalized, status, last,
		output ready);
endinterface

// ===== sv/zsn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module zsn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/zsn_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module zsn_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [zsn_pkg::DVD_W-1:0]   dividend,
	input  logic [zsn_pkg::DVS_W-1:0]   divisor,
	output logic                        done,
	output logic [zsn_pkg::DVD_W-1:0]   quotient
);
	localparam int CW = $clog2(zsn_pkg::DVD_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CW-1:0]             cnt_q;
	logic [zsn_pkg::DVD_W-1:0] dvd_q;
	logic [zsn_pkg::DVS_W-1:0] dvs_q;
	logic [zsn_pkg::DVS_W-1:0] rem_q;
	logic [zsn_pkg::DVS_W:0]   rem_sh;
	logic [zsn_pkg::DVS_W:0]   rem_sub;
	logic                      qbit;

	assign rem_sh  = {rem_q, dvd_q[zsn_pkg::DVD_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign qbit    = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(zsn_pkg::DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[zsn_pkg::DVD_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[zsn_pkg::DVS_W-1:0] : rem_sh[zsn_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !start) |=> (cnt_q == '0 || busy_q))
		else $error("divider counter left nonzero");
endmodule

// ===== sv/zsn_sqrt.sv =====
// Digit-serial integer square root: two radicand bits, one root bit per cycle.
module zsn_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [zsn_pkg::SQ_W-1:0]    radicand,
	output logic                        done,
	output logic [zsn_pkg::ROOT_W-1:0]  root
);
	localparam int CW  = $clog2(zsn_pkg::ROOT_W);
	localparam int RMW = zsn_pkg::ROOT_W + 2;

	logic                       busy_q;
	logic                       done_q;
	logic [CW-1:0]              cnt_q;
	logic [zsn_pkg::SQ_W-1:0]   v_q;
	logic [RMW-1:0]             rem_q;
	logic [zsn_pkg::ROOT_W-1:0] root_q;
	logic [RMW+1:0]             rem_sh;
	logic [RMW+1:0]             trial;
	logic [RMW+1:0]             rem_sub;
	logic                       ge;

	assign rem_sh  = {rem_q, v_q[zsn_pkg::SQ_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign rem_sub = rem_sh - trial;
	assign ge      = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(zsn_pkg::ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[zsn_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[RMW-1:0] : rem_sh[RMW-1:0];
			root_q <= {root_q[zsn_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== sv/zsn_mul.sv =====
// Bit-serial shift-add squarer: one multiplier bit per cycle.
module zsn_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [zsn_pkg::MUL_W-1:0]    a,
	output logic                         done,
	output logic [2*zsn_pkg::MUL_W-1:0]  product
);
	localparam int CW = $clog2(zsn_pkg::MUL_W);
	localparam int W  = zsn_pkg::MUL_W;

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [W-1:0]   mcand_q;
	logic [2*W-1:0] prod_q;
	logic [W:0]     psum;

	assign psum = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= a;
			prod_q  <= {{W{1'b0}}, a};
		end else if (busy_q) begin
			prod_q <= {psum, prod_q[W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;
endmodule

// ===== sv/feature_zscore_normalizer_top.sv =====
// Top level of the feature z-score normalizer: control, config port, sample store.
//
// Load words write one Q15.16 sample into the sample store and are taken one per
// cycle while the sequencer is idle. A read word goes through a store read, then the
// result register. A finish word walks the store feature by feature through a
// single sequencer: a summing pass over the rows, a serial mean divide, a squaring
// pass on the bit-serial squarer, a serial variance divide and square root, and a
// normalizing pass on the shared bit-serial divider. A single-row matrix skips the
// squaring and normalizing passes, and a feature whose deviation is zero skips the
// normalizing pass; either clears its column row by row. One statistics word per
// feature leaves through an output register, so the input side is never held by a
// waiting result except while a finish or read is in flight. The sample store has
// no reset; reading an element in use that was never loaded gives an unspecified
// value.
module feature_zscore_normalizer_top #(
	parameter int MAX_ROWS     = zsn_pkg::MAX_ROWS_DEF,
	parameter int MAX_FEATURES = zsn_pkg::MAX_FEATURES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	zsn_in_if.sink                        req,
	zsn_out_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [zsn_pkg::PADDR_W-1:0]   paddr,
	input  logic [zsn_pkg::PDATA_W-1:0]   pwdata,
	output logic [zsn_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	localparam int DEPTH = MAX_ROWS * MAX_FEATURES;
	localparam int AW    = $clog2(DEPTH);
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int FCW   = $clog2(MAX_FEATURES + 1);
	localparam int RIW   = $clog2(MAX_ROWS);
	localparam int FIW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int SW    = 32 + RIW;
	localparam logic REG_NUM_FEATURES_C = zsn_pkg::REG_NUM_FEATURES;

	// Sequencer states
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_READ    = 5'd1;
	localparam logic [4:0] ST_SUM_RD  = 5'd2;
	localparam logic [4:0] ST_SUM_ACC = 5'd3;
	localparam logic [4:0] ST_MEAN_GO = 5'd4;
	localparam logic [4:0] ST_MEAN_WT = 5'd5;
	localparam logic [4:0] ST_SQ_RD   = 5'd6;
	localparam logic [4:0] ST_SQ_GO   = 5'd7;
	localparam logic [4:0] ST_SQ_WT   = 5'd8;
	localparam logic [4:0] ST_VAR_GO  = 5'd9;
	localparam logic [4:0] ST_VAR_WT  = 5'd10;
	localparam logic [4:0] ST_SQRT_WT = 5'd11;
	localparam logic [4:0] ST_NRM_RD  = 5'd12;
	localparam logic [4:0] ST_NRM_GO  = 5'd13;
	localparam logic [4:0] ST_NRM_WT  = 5'd14;
	localparam logic [4:0] ST_ZERO    = 5'd15;
	localparam logic [4:0] ST_EMIT    = 5'd16;

	logic [4:0]                  state_q;
	logic                        finished_q;
	logic [zsn_pkg::NF_W-1:0]    nf_q;
	logic [zsn_pkg::NR_W-1:0]    nr_q;
	logic [RIW-1:0]              ridx_q;
	logic [FIW-1:0]              fidx_q;
	logic [AW-1:0]               addr_q;
	logic signed [SW-1:0]        sum_q;
	logic [31:0]                 mean_q;
	zsn_pkg::std_t               sd_q;
	logic [63:0]                 acc_q;
	logic                        neg_q;
	logic                        rd_ok_q;
	zsn_pkg::feat_t              rfeat_q;

	logic                        out_valid_q;
	zsn_pkg::feat_t              o_feat_q;
	zsn_pkg::sample_t            o_mean_q;
	zsn_pkg::std_t               o_std_q;
	zsn_pkg::sample_t            o_norm_q;
	logic                        o_status_q;
	logic                        o_last_q;

	logic [RCW-1:0]              rows_used;
	logic [FCW-1:0]              feats_used;
	logic                        in_fire;
	logic                        in_ok;
	logic [AW-1:0]               in_addr;
	logic                        cfg_wr;
	logic                        out_free;
	logic                        out_load;
	logic                        last_row;
	logic                        last_feat;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [31:0]                 ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [31:0]                 ram_rdata;

	logic                        div_start;
	logic [zsn_pkg::DVD_W-1:0]   div_dvd;
	logic [zsn_pkg::DVS_W-1:0]   div_dvs;
	logic                        div_done;
	logic [zsn_pkg::DVD_W-1:0]   div_quo;
	logic                        mul_start;
	logic                        mul_done;
	logic [2*zsn_pkg::MUL_W-1:0] mul_prod;
	logic                        sqrt_done;
	logic [zsn_pkg::ROOT_W-1:0]  sqrt_root;

	logic [SW-1:0]               sum_mag;
	logic [32:0]                 dev;
	logic [32:0]                 dev_abs;
	logic [31:0]                 mean_w;
	logic [31:0]                 nrm_w;
	logic [64:0]                 acc_sum;
	zsn_pkg::std_t               sd_w;

	// Clamp the config registers to the sizes the store holds; zero counts as one
	assign rows_used = (nr_q == '0) ? RCW'(1) :
		(32'(nr_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(nr_q);
	assign feats_used = (nf_q == '0) ? FCW'(1) :
		(32'(nf_q) > MAX_FEATURES) ? FCW'(MAX_FEATURES) : FCW'(nf_q);

	assign in_fire  = req.valid && req.ready;
	assign in_ok    = (32'(req.row) < 32'(rows_used)) && (32'(req.feature) < 32'(feats_used));
	assign in_addr  = AW'(32'(req.row) * MAX_FEATURES + 32'(req.feature));
	assign req.ready = (state_q == ST_IDLE);

	assign last_row  = (32'(ridx_q) + 32'd1 == 32'(rows_used));
	assign last_feat = (32'(fidx_q) + 32'd1 == 32'(feats_used));
	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = out_free && (state_q == ST_READ || state_q == ST_EMIT);

	// Config port: setup then access phase, never waits
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			REG_NUM_FEATURES_C: prdata = {{(zsn_pkg::PDATA_W - zsn_pkg::NF_W){1'b0}}, nf_q};
			default:            prdata = {{(zsn_pkg::PDATA_W - zsn_pkg::NR_W){1'b0}}, nr_q};
		endcase
	end

	// Datapath terms
	assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign mean_w  = sum_q[SW-1] ? 32'(-div_quo[31:0]) : div_quo[31:0];
	assign dev     = {ram_rdata[31], ram_rdata} - {mean_q[31], mean_q};
	assign dev_abs = dev[32] ? 33'(-dev) : dev;
	assign acc_sum = {1'b0, acc_q} + {1'b0, mul_prod};
	assign sd_w    = sqrt_root[zsn_pkg::ROOT_W-1] ? zsn_pkg::STD_MAX
		: sqrt_root[zsn_pkg::STD_W-1:0];

	// Saturate the signed quotient to the 32-bit range
	always_comb begin
		if (neg_q) begin
			nrm_w = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
		end else begin
			nrm_w = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
		end
	end

	// Store and arithmetic unit steering
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = nrm_w;
		div_start = 1'b0;
		div_dvd   = 64'(sum_mag);
		div_dvs   = 32'(rows_used);
		mul_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = in_addr;
				ram_waddr = in_addr;
				ram_wdata = req.value;
				ram_re    = in_fire && (req.action == zsn_pkg::ACT_READ);
				ram_we    = in_fire && (req.action == zsn_pkg::ACT_LOAD) && in_ok;
			end
			ST_SUM_RD, ST_SQ_RD, ST_NRM_RD: begin
				ram_re = 1'b1;
			end
			ST_MEAN_GO: begin
				div_start = 1'b1;
			end
			ST_SQ_GO: begin
				mul_start = 1'b1;
			end
			ST_VAR_GO: begin
				div_start = 1'b1;
				div_dvd   = acc_q;
				div_dvs   = 32'(rows_used) - 32'd1;
			end
			ST_NRM_GO: begin
				div_start = 1'b1;
				div_dvd   = {16'd0, dev_abs[31:0], 16'd0};
				div_dvs   = {1'b0, sd_q};
			end
			ST_NRM_WT: begin
				ram_we = div_done;
			end
			ST_ZERO: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Sequencer: walk rows of one feature per pass, features in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			finished_q <= 1'b0;
			nf_q       <= zsn_pkg::NF_W'(zsn_pkg::NF_RESET);
			nr_q       <= zsn_pkg::NR_W'(zsn_pkg::NR_RESET);
			ridx_q     <= '0;
			fidx_q     <= '0;
			addr_q     <= '0;
			sum_q      <= '0;
			mean_q     <= '0;
			sd_q       <= '0;
			acc_q      <= '0;
			neg_q      <= 1'b0;
			rd_ok_q    <= 1'b0;
			rfeat_q    <= '0;
		end else begin
			if (cfg_wr) begin
				finished_q <= 1'b0;
				case (paddr[2])
					REG_NUM_FEATURES_C: nf_q <= pwdata[zsn_pkg::NF_W-1:0];
					default:            nr_q <= pwdata[zsn_pkg::NR_W-1:0];
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (req.action)
							zsn_pkg::ACT_LOAD: begin
								if (in_ok) begin
									finished_q <= 1'b0;
								end
							end
							zsn_pkg::ACT_FINISH: begin
								fidx_q  <= '0;
								ridx_q  <= '0;
								addr_q  <= '0;
								sum_q   <= '0;
								state_q <= ST_SUM_RD;
							end
							zsn_pkg::ACT_READ: begin
								rd_ok_q <= in_ok && finished_q;
								rfeat_q <= req.feature;
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM_RD: begin
					state_q <= ST_SUM_ACC;
				end
				ST_SUM_ACC: begin
					sum_q <= sum_q + SW'(signed'(ram_rdata));
					if (last_row) begin
						state_q <= ST_MEAN_GO;
					end else begin
						ridx_q  <= ridx_q + 1'b1;
						addr_q  <= addr_q + AW'(MAX_FEATURES);
						state_q <= ST_SUM_RD;
					end
				end
				ST_MEAN_GO: begin
					state_q <= ST_MEAN_WT;
				end
				ST_MEAN_WT: begin
					if (div_done) begin
						ridx_q <= '0;
						addr_q <= AW'(fidx_q);
						acc_q  <= '0;
						if (rows_used == RCW'(1)) begin
							// single row: force unit deviation and clear the column
							mean_q  <= '0;
							sd_q    <= zsn_pkg::ONE_Q16;
							state_q <= ST_ZERO;
						end else begin
							mean_q  <= mean_w;
							state_q <= ST_SQ_RD;
						end
					end
				end
				ST_SQ_RD: begin
					state_q <= ST_SQ_GO;
				end
				ST_SQ_GO: begin
					state_q <= ST_SQ_WT;
				end
				ST_SQ_WT: begin
					if (mul_done) begin
						acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
						if (last_row) begin
							state_q <= ST_VAR_GO;
						end else begin
							ridx_q  <= ridx_q + 1'b1;
							addr_q  <= addr_q + AW'(MAX_FEATURES);
							state_q <= ST_SQ_RD;
						end
					end
				end
				ST_VAR_GO: begin
					state_q <= ST_VAR_WT;
				end
				ST_VAR_WT: begin
					if (div_done) begin
						state_q <= ST_SQRT_WT;
					end
				end
				ST_SQRT_WT: begin
					if (sqrt_done) begin
						ridx_q <= '0;
						addr_q <= AW'(fidx_q);
						if (sd_w == '0) begin
							mean_q  <= '0;
							sd_q    <= zsn_pkg::ONE_Q16;
							state_q <= ST_ZERO;
						end else begin
							sd_q    <= sd_w;
							state_q <= ST_NRM_RD;
						end
					end
				end
				ST_NRM_RD: begin
					state_q <= ST_NRM_GO;
				end
				ST_NRM_GO: begin
					neg_q   <= dev[32];
					state_q <= ST_NRM_WT;
				end
				ST_NRM_WT: begin
					if (div_done) begin
						if (last_row) begin
							state_q <= ST_EMIT;
						end else begin
							ridx_q  <= ridx_q + 1'b1;
							addr_q  <= addr_q + AW'(MAX_FEATURES);
							state_q <= ST_NRM_RD;
						end
					end
				end
				ST_ZERO: begin
					if (last_row) begin
						state_q <= ST_EMIT;
					end else begin
						ridx_q <= ridx_q + 1'b1;
						addr_q <= addr_q + AW'(MAX_FEATURES);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (last_feat) begin
							finished_q <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							fidx_q  <= fidx_q + 1'b1;
							ridx_q  <= '0;
							addr_q  <= AW'(fidx_q) + AW'(1);
							sum_q   <= '0;
							state_q <= ST_SUM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: hold a word until taken; load a new word only when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_READ) begin
				o_feat_q   <= rfeat_q;
				o_mean_q   <= '0;
				o_std_q    <= '0;
				o_norm_q   <= rd_ok_q ? ram_rdata : '0;
				o_status_q <= !rd_ok_q;
				o_last_q   <= 1'b0;
			end else begin
				o_feat_q   <= zsn_pkg::FEAT_W'(fidx_q);
				o_mean_q   <= mean_q;
				o_std_q    <= sd_q;
				o_norm_q   <= '0;
				o_status_q <= 1'b0;
				o_last_q   <= last_feat;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.feature_index = o_feat_q;
	assign rsp.mean          = o_mean_q;
	assign rsp.std_dev       = o_std_q;
	assign rsp.normalized    = o_norm_q;
	assign rsp.status        = o_status_q;
	assign rsp.last          = o_last_q;

	zsn_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	zsn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_quo)
	);

	zsn_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (dev_abs[31:0]),
		.done   (mul_done),
		.product(mul_prod)
	);

	zsn_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_VAR_WT && div_done),
		.radicand(div_quo),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	a_finish_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(finished_q) |-> $past(state_q) == ST_EMIT)
		else $error("finished flag set outside the statistics step");
	a_nonzero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NRM_GO |-> sd_q != '0)
		else $error("normalize pass started with zero deviation");
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_READ) |-> 32'(ridx_q) < 32'(rows_used))
		else $error("row walk ran past the rows in use");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten before taken");
endmodule

// ===== tb/feature_zscore_normalizer_top_test.sv =====
// Self-checking testbench of the feature z-score normalizer top level.
`timescale 1ns / 100ps

module feature_zscore_normalizer_top_test;
	localparam int MAXR = zsn_pkg::MAX_ROWS_DEF;
	localparam int MAXF = zsn_pkg::MAX_FEATURES_DEF;
	localparam int STALL_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 20;
	localparam zsn_pkg::action_t ACT_NONE = 2'd3;

	// One expected result word
	typedef struct {
		zsn_pkg::feat_t   feature_index;
		zsn_pkg::sample_t mean;
		zsn_pkg::std_t    std_dev;
		zsn_pkg::sample_t normalized;
		logic             status;
		logic             last;
	} zsn_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [zsn_pkg::PADDR_W-1:0] paddr = '0;
	logic [zsn_pkg::PDATA_W-1:0] pwdata = '0;
	logic [zsn_pkg::PDATA_W-1:0] prdata;
	logic pready;

	zsn_in_if req_if ();
	zsn_out_if rsp_if ();

	feature_zscore_normalizer_top dut (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block state used to predict every result word
	logic [31:0] shadow_mem [0:MAXR*MAXF-1];
	int unsigned shadow_nf = zsn_pkg::NF_RESET;
	int unsigned shadow_nr = zsn_pkg::NR_RESET;
	bit stats_valid = 1'b0;
	zsn_result_t pending_q [$];

	int unsigned sender_gap = 0;
	int unsigned sink_stall = 0;
	int unsigned mismatch_count = 0;
	int unsigned result_count = 0;
	int unsigned finish_count = 0;
	int unsigned read_count = 0;
	int unsigned quiet_cycles = 0;

	function automatic int unsigned feats_in_use();
		if (shadow_nf == 0) return 1;
		if (shadow_nf > MAXF) return MAXF;
		return shadow_nf;
	endfunction

	function automatic int unsigned rows_in_use();
		if (shadow_nr == 0) return 1;
		if (shadow_nr > MAXR) return MAXR;
		return shadow_nr;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic longint sample_at(int unsigned r, int unsigned f);
		return longint'($signed(shadow_mem[r*MAXF+f]));
	endfunction

	// Compute mean and sample std of every feature in use, normalize the columns in place
	task automatic predict_statistics();
		int unsigned nf;
		int unsigned nr;
		longint sum;
		longint mean;
		longint d;
		longint q;
		longint unsigned mag;
		longint unsigned sq;
		longint unsigned sq_sum;
		longint unsigned sd;
		zsn_result_t e;
		nf = feats_in_use();
		nr = rows_in_use();
		for (int unsigned f = 0; f < nf; f++) begin
			sum = 0;
			for (int unsigned r = 0; r < nr; r++) sum += sample_at(r, f);
			mean = sum / longint'(nr);
			sq_sum = 0;
			for (int unsigned r = 0; r < nr; r++) begin
				d = sample_at(r, f) - mean;
				mag = (d < 0) ? -d : d;
				sq = mag * mag;
				// hold the square sum at its ceiling
				if (sq_sum > ~64'd0 - sq) sq_sum = ~64'd0;
				else sq_sum += sq;
			end
			sd = 0;
			if (nr > 1) sd = int_sqrt(sq_sum / (nr - 1));
			if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
			if (nr == 1 || sd == 0) begin
				// degenerate column: force unit std, zero mean, clear the column
				sd = zsn_pkg::ONE_Q16;
				mean = 0;
				for (int unsigned r = 0; r < nr; r++) shadow_mem[r*MAXF+f] = '0;
			end else begin
				for (int unsigned r = 0; r < nr; r++) begin
					d = sample_at(r, f) - mean;
					q = (d * 65536) / longint'(sd);
					if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
					if (q < -64'sh8000_0000) q = -64'sh8000_0000;
					shadow_mem[r*MAXF+f] = q[31:0];
				end
			end
			e.feature_index = f[zsn_pkg::FEAT_W-1:0];
			e.mean = mean[31:0];
			e.std_dev = sd[zsn_pkg::STD_W-1:0];
			e.normalized = '0;
			e.status = 1'b0;
			e.last = (f + 1 == nf);
			pending_q.push_back(e);
		end
		stats_valid = 1'b1;
	endtask

	// Update the shadow state for one accepted word and queue what it should produce
	task automatic predict_word(zsn_pkg::action_t a, zsn_pkg::sample_t v, zsn_pkg::row_t r,
		zsn_pkg::feat_t f);
		bit in_use;
		zsn_result_t e;
		in_use = (r < rows_in_use()) && (f < feats_in_use());
		case (a)
			zsn_pkg::ACT_LOAD: begin
				if (in_use) begin
					shadow_mem[r*MAXF+f] = v;
					stats_valid = 1'b0;
				end
			end
			zsn_pkg::ACT_FINISH: begin
				predict_statistics();
			end
			zsn_pkg::ACT_READ: begin
				e.feature_index = f;
				e.mean = '0;
				e.std_dev = '0;
				e.last = 1'b0;
				e.normalized = (in_use && stats_valid) ? shadow_mem[r*MAXF+f] : '0;
				e.status = !(in_use && stats_valid);
				pending_q.push_back(e);
			end
			default: begin
			end
		endcase
	endtask

	// Send one word, with random gaps ahead of it
	task automatic send_word(zsn_pkg::action_t a, zsn_pkg::sample_t v, zsn_pkg::row_t r,
		zsn_pkg::feat_t f);
		while ($urandom_range(99) < sender_gap) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.action = a;
		req_if.value = v;
		req_if.row = r;
		req_if.feature = f;
		do @(posedge clk); while (!req_if.ready);
		predict_word(a, v, r, f);
		@(negedge clk);
		req_if.valid = 1'b0;
	endtask

	// Wait until every queued result has come back and the block has settled
	task automatic wait_idle();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(logic idx, int unsigned value);
		wait_idle();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == zsn_pkg::REG_NUM_FEATURES) shadow_nf = value & 32'h1F;
		else shadow_nr = value & 32'h7FF;
		stats_valid = 1'b0;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_shape(int unsigned nf, int unsigned nr);
		write_reg(zsn_pkg::REG_NUM_FEATURES, nf);
		write_reg(zsn_pkg::REG_NUM_ROWS, nr);
	endtask

	function automatic zsn_pkg::sample_t random_sample();
		case ($urandom_range(3))
			0: return $urandom;
			1: return zsn_pkg::sample_t'($signed(20'($urandom)));
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return zsn_pkg::sample_t'($signed(8'($urandom)) <<< 16);
		endcase
	endfunction

	// Load every element in use so a finish never touches an unwritten cell
	task automatic fill_matrix();
		for (int unsigned r = 0; r < rows_in_use(); r++)
			for (int unsigned f = 0; f < feats_in_use(); f++)
				send_word(zsn_pkg::ACT_LOAD, random_sample(), zsn_pkg::row_t'(r),
					zsn_pkg::feat_t'(f));
	endtask

	task automatic set_idling(int unsigned mode);
		case (mode % 3)
			0: begin sender_gap = 8; sink_stall = 73; end
			1: begin sender_gap = 73; sink_stall = 8; end
			default: begin sender_gap = 0; sink_stall = 0; end
		endcase
	endtask

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Receiver stalls at random; change ready on the falling edge only
	always @(negedge clk) rsp_if.ready <= ($urandom_range(99) >= sink_stall);

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		zsn_result_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			result_count++;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result word", rsp_if.feature_index, 0);
			end else begin
				e = pending_q.pop_front();
				if (rsp_if.feature_index !== e.feature_index)
					report_mismatch("feature_index", rsp_if.feature_index, e.feature_index);
				if (rsp_if.mean !== e.mean) report_mismatch("mean", rsp_if.mean, e.mean);
				if (rsp_if.std_dev !== e.std_dev)
					report_mismatch("std_dev", rsp_if.std_dev, e.std_dev);
				if (rsp_if.normalized !== e.normalized)
					report_mismatch("normalized", rsp_if.normalized, e.normalized);
				if (rsp_if.status !== e.status)
					report_mismatch("status", rsp_if.status, e.status);
				if (rsp_if.last !== e.last) report_mismatch("last", rsp_if.last, e.last);
			end
		end
	end

	// Watchdog: end the run when no word moves on either channel for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Small matrix with hand-picked columns: extremes, a constant column, random data
	task automatic test_directed();
		zsn_pkg::sample_t col0 [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000};
		set_idling(0);
		set_shape(3, 4);
		// read before any finish must flag an error
		send_word(zsn_pkg::ACT_READ, '0, 0, 0);
		for (int unsigned r = 0; r < 4; r++) begin
			send_word(zsn_pkg::ACT_LOAD, col0[r], zsn_pkg::row_t'(r), 0);
			send_word(zsn_pkg::ACT_LOAD, 32'h0001_8000, zsn_pkg::row_t'(r), 1);
			send_word(zsn_pkg::ACT_LOAD, $urandom, zsn_pkg::row_t'(r), 2);
		end
		// dropped words: unused action and loads outside the matrix
		send_word(ACT_NONE, $urandom, 1, 1);
		send_word(zsn_pkg::ACT_LOAD, 32'hFFFF_FFFF, 4, 0);
		send_word(zsn_pkg::ACT_LOAD, 32'h1234_5678, 0, 3);
		send_word(zsn_pkg::ACT_LOAD, 32'h0, 10'h3FF, 4'hF);
		send_word(zsn_pkg::ACT_FINISH, '0, 0, 0);
		send_word(zsn_pkg::ACT_READ, '0, 0, 0);
		send_word(zsn_pkg::ACT_READ, '0, 3, 1);
		send_word(zsn_pkg::ACT_READ, '0, 2, 2);
		send_word(zsn_pkg::ACT_READ, '0, 10'h3FF, 4'hF);
		// second finish normalizes the already normalized store
		send_word(zsn_pkg::ACT_FINISH, '0, 0, 0);
		send_word(zsn_pkg::ACT_READ, '0, 1, 0);
	endtask

	// Single row and zero registers: every column forced to unit std
	task automatic test_single_row();
		set_idling(1);
		set_shape(0, 0);
		send_word(zsn_pkg::ACT_LOAD, 32'h0042_0000, 0, 0);
		send_word(zsn_pkg::ACT_FINISH, '0, 0, 0);
		send_word(zsn_pkg::ACT_READ, '0, 0, 0);
		set_shape(2, 1);
		fill_matrix();
		send_word(zsn_pkg::ACT_FINISH, '0, 0, 0);
		send_word(zsn_pkg::ACT_READ, '0, 0, 1);
	endtask

	// Widest and tallest settings, including values above the maximum
	task automatic test_extreme_shapes();
		set_idling(2);
		set_shape(31, 2);
		fill_matrix();
		send_word(zsn_pkg::ACT_FINISH, '0, 0, 0);
		send_word(zsn_pkg::ACT_READ, '0, 1, 15);
		set_shape(16, 2047);
		send_word(zsn_pkg::ACT_LOAD, 32'h0000_0001, 10'h3FF, 4'hF);
		send_word(zsn_pkg::ACT_READ, '0, 10'h3FF, 4'hF);
		set_shape(1, 1024);
		send_word(zsn_pkg::ACT_LOAD, 32'h0000_0002, 10'h3FF, 0);
		send_word(zsn_pkg::ACT_READ, '0, 512, 0);
	endtask

	// Random shapes, full loads, then a mix of reloads, reads, noise and finishes
	task automatic test_random(int unsigned target);
		int unsigned sent;
		int unsigned phase;
		int unsigned pick;
		sent = 0;
		phase = 0;
		while (sent < target) begin
			set_idling(phase);
			set_shape($urandom_range(1, 6), $urandom_range(2, 8));
			fill_matrix();
			sent += feats_in_use() * rows_in_use();
			repeat ($urandom_range(15, 35)) begin
				pick = $urandom_range(99);
				if (pick < 40)
					send_word(zsn_pkg::ACT_LOAD, random_sample(),
						zsn_pkg::row_t'($urandom_range(rows_in_use() - 1)),
						zsn_pkg::feat_t'($urandom_range(feats_in_use() - 1)));
				else if (pick < 48)
					send_word(zsn_pkg::ACT_LOAD, $urandom, zsn_pkg::row_t'($urandom),
						zsn_pkg::feat_t'($urandom));
				else if (pick < 78)
					send_word(zsn_pkg::ACT_READ, $urandom,
						zsn_pkg::row_t'($urandom_range(rows_in_use())),
						zsn_pkg::feat_t'($urandom_range(feats_in_use())));
				else if (pick < 83)
					send_word(ACT_NONE, $urandom, zsn_pkg::row_t'($urandom),
						zsn_pkg::feat_t'($urandom));
				else
					send_word(zsn_pkg::ACT_FINISH, $urandom, zsn_pkg::row_t'($urandom),
						zsn_pkg::feat_t'($urandom));
				sent++;
			end
			send_word(zsn_pkg::ACT_FINISH, '0, 0, 0);
			send_word(zsn_pkg::ACT_READ, '0, 0, 0);
			sent += 2;
			phase++;
		end
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.action = zsn_pkg::ACT_LOAD;
		req_if.value = '0;
		req_if.row = '0;
		req_if.feature = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_single_row();
		test_extreme_shapes();
		test_random(340);
		wait_idle();
		repeat (50) @(negedge clk);
		$display("covered %0d result words: %0d statistics runs checked, up to 16 features",
			result_count, finish_count);
		$display("%0d mismatches over directed, single-row, extreme and random phases",
			mismatch_count);
		if (mismatch_count == 0 && pending_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Count finish runs by their last word for the summary
	always @(posedge clk)
		if (arst_n && rsp_if.valid && rsp_if.ready && rsp_if.last) finish_count++;

endmodule

// ===== files.f =====
sv/zsn_pkg.sv
sv/zsn_in_if.sv
sv/zsn_out_if.sv
sv/zsn_ram.sv
sv/zsn_div.sv
sv/zsn_sqrt.sv
sv/zsn_mul.sv
sv/feature_zscore_normalizer_top.sv
tb/feature_zscore_normalizer_top_test.sv
